### hw/rtl/fpk_pkg.sv
package fpk_pkg;

  localparam int SigW  = 113;
  localparam int ExtW  = SigW + 1;
  localparam int ShW   = 7;
  localparam int ExpW  = 18;

  typedef enum logic [1:0] {FMT_INT32, FMT_SINGLE, FMT_DOUBLE, FMT_QUAD} fmt_t;
  typedef enum logic [1:0] {CLS_ZERO, CLS_NORMAL, CLS_INF, CLS_NAN} cls_t;
  typedef enum logic [1:0] {RM_NEAREST, RM_ZERO, RM_UP, RM_DOWN} rm_t;

  typedef struct packed {
    logic [1:0]         target_format;
    logic [1:0]         value_class;
    logic               sign;
    logic signed [15:0] exponent;
    logic [48:0]        significand_high;
    logic [63:0]        significand_low;
    logic               guard_bit;
    logic               sticky_bit;
  } item_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
    logic        inexact_flag;
    logic        underflow_flag;
    logic        overflow_flag;
    logic        invalid_flag;
  } result_t;

  // Control that travels with each item down the pipe
  typedef struct packed {
    logic                   valid;
    fmt_t                   fmt;
    cls_t                   cls;
    logic                   sign;
    rm_t                    mode;
    logic signed [ExpW-1:0] ebias;
    logic                   tiny;
    logic                   int_ok;
  } ctl_t;

  localparam logic signed [ExpW-1:0] BiasSingle = 18'sd127;
  localparam logic signed [ExpW-1:0] BiasDouble = 18'sd1023;
  localparam logic signed [ExpW-1:0] BiasQuad   = 18'sd16383;
  localparam logic signed [ExpW-1:0] EmaxSingle = 18'sd255;
  localparam logic signed [ExpW-1:0] EmaxDouble = 18'sd2047;
  localparam logic signed [ExpW-1:0] EmaxQuad   = 18'sd32767;

  localparam logic signed [ExpW:0] PreShiftSingle = 19'sd89;
  localparam logic signed [ExpW:0] PreShiftDouble = 19'sd60;
  localparam logic signed [ExpW:0] IntPoint       = 19'sd112;
  localparam logic signed [ExpW:0] ShiftCap       = 19'sd127;
  localparam logic signed [ExpW-1:0] IntLimit     = 18'sd32;

endpackage

### hw/rtl/fpk_align.sv
module fpk_align (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    accept,
  input  fpk_pkg::item_t          item,
  input  fpk_pkg::rm_t            mode,
  output fpk_pkg::ctl_t           ctl,
  output logic [fpk_pkg::SigW-1:0] sig,
  output logic                    g,
  output logic                    s
);

  logic signed [fpk_pkg::ExpW-1:0] e_ext;
  logic signed [fpk_pkg::ExpW-1:0] bias;
  logic signed [fpk_pkg::ExpW-1:0] ebias;
  logic signed [fpk_pkg::ExpW:0]   k_full;
  logic signed [fpk_pkg::ExpW:0]   denorm;
  logic [fpk_pkg::ShW-1:0]         k_cap;
  logic                            tiny_c;
  fpk_pkg::fmt_t                   fmt_c;
  fpk_pkg::cls_t                   cls_c;
  fpk_pkg::ctl_t                   ctl_next;

  fpk_pkg::ctl_t                   d_ctl;
  logic [fpk_pkg::SigW-1:0]        d_sig;
  logic                            d_g;
  logic                            d_s;
  logic [fpk_pkg::ShW-1:0]         d_k;

  logic [fpk_pkg::ExtW-1:0]        v;
  logic [fpk_pkg::ExtW-1:0]        vs;
  logic [fpk_pkg::ExtW-1:0]        lowmask;

  // Decode: biased exponent and total right shift
  always_comb begin
    fmt_c = fpk_pkg::fmt_t'(item.target_format);
    cls_c = fpk_pkg::cls_t'(item.value_class);
    e_ext = {{(fpk_pkg::ExpW-16){item.exponent[15]}}, item.exponent};
    case (fmt_c)
      fpk_pkg::FMT_SINGLE: bias = fpk_pkg::BiasSingle;
      fpk_pkg::FMT_DOUBLE: bias = fpk_pkg::BiasDouble;
      fpk_pkg::FMT_QUAD:   bias = fpk_pkg::BiasQuad;
      default:             bias = '0;
    endcase
    ebias  = e_ext + bias;
    tiny_c = (cls_c == fpk_pkg::CLS_NORMAL) && (fmt_c != fpk_pkg::FMT_INT32) &&
             (ebias <= 18'sd0);
    denorm = tiny_c ? (19'sd1 - {ebias[fpk_pkg::ExpW-1], ebias}) : 19'sd0;
    case (fmt_c)
      fpk_pkg::FMT_INT32:  k_full = fpk_pkg::IntPoint - {e_ext[fpk_pkg::ExpW-1], e_ext};
      fpk_pkg::FMT_SINGLE: k_full = fpk_pkg::PreShiftSingle + denorm;
      fpk_pkg::FMT_DOUBLE: k_full = fpk_pkg::PreShiftDouble + denorm;
      default:             k_full = denorm;
    endcase
    if (k_full < 19'sd0) begin
      k_cap = '0;
    end else if (k_full > fpk_pkg::ShiftCap) begin
      k_cap = fpk_pkg::ShiftCap[fpk_pkg::ShW-1:0];
    end else begin
      k_cap = k_full[fpk_pkg::ShW-1:0];
    end
    ctl_next.valid  = accept;
    ctl_next.fmt    = fmt_c;
    ctl_next.cls    = cls_c;
    ctl_next.sign   = item.sign;
    ctl_next.mode   = mode;
    ctl_next.ebias  = ebias;
    ctl_next.tiny   = tiny_c;
    ctl_next.int_ok = (cls_c == fpk_pkg::CLS_NORMAL) && (e_ext < fpk_pkg::IntLimit);
  end

  // Capture the decoded item
  always_ff @(posedge clk) begin
    if (rst) begin
      d_ctl.valid <= 1'b0;
    end else begin
      d_ctl <= ctl_next;
    end
    d_sig <= {item.significand_high, item.significand_low};
    d_g   <= item.guard_bit;
    d_s   <= item.sticky_bit;
    d_k   <= k_cap;
  end

  // Shift right, keeping guard and folding the rest into sticky
  always_comb begin
    v       = {d_sig, d_g};
    vs      = v >> d_k;
    lowmask = ~({fpk_pkg::ExtW{1'b1}} << d_k);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else begin
      ctl <= d_ctl;
    end
    sig <= vs[fpk_pkg::ExtW-1:1];
    g   <= vs[0];
    s   <= d_s | (|(v & lowmask));
  end

endmodule

### hw/rtl/fpk_round.sv
module fpk_round (
  input  logic                     clk,
  input  logic                     rst,
  input  fpk_pkg::ctl_t            in_ctl,
  input  logic [fpk_pkg::SigW-1:0] sig,
  input  logic                     g,
  input  logic                     s,
  output fpk_pkg::ctl_t            ctl,
  output logic [fpk_pkg::ExtW-1:0] rounded,
  output logic                     inexact
);

  logic                     active;
  logic                     inc;
  logic [fpk_pkg::ExtW-1:0] sum;

  // Round in the selected direction, ties to even
  always_comb begin
    active = (in_ctl.cls == fpk_pkg::CLS_NORMAL) && (g | s);
    case (in_ctl.mode)
      fpk_pkg::RM_NEAREST: inc = g;
      fpk_pkg::RM_ZERO:    inc = 1'b0;
      fpk_pkg::RM_UP:      inc = !in_ctl.sign;
      fpk_pkg::RM_DOWN:    inc = in_ctl.sign;
      default:             inc = 1'b0;
    endcase
    inc = inc && active;
    sum = {1'b0, sig} + {{(fpk_pkg::ExtW-1){1'b0}}, inc};
    if (inc && (in_ctl.mode == fpk_pkg::RM_NEAREST) && !s) begin
      sum[0] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else begin
      ctl <= in_ctl;
    end
    rounded <= sum;
    inexact <= active;
  end

endmodule

### hw/rtl/fpk_pack.sv
module fpk_pack (
  input  logic                     clk,
  input  logic                     rst,
  input  fpk_pkg::ctl_t            in_ctl,
  input  logic [fpk_pkg::ExtW-1:0] r,
  input  logic                     inexact,
  output logic                     done,
  output fpk_pkg::result_t         result
);

  fpk_pkg::result_t                res_next;
  logic                            to_inf;
  logic                            sgn;
  logic                            int_fit;
  logic signed [fpk_pkg::ExpW-1:0] e_s;
  logic signed [fpk_pkg::ExpW-1:0] e_d;
  logic signed [fpk_pkg::ExpW-1:0] e_q;

  // Pack into the target format and raise flags
  always_comb begin
    sgn = in_ctl.sign;
    case (in_ctl.mode)
      fpk_pkg::RM_NEAREST: to_inf = 1'b1;
      fpk_pkg::RM_ZERO:    to_inf = 1'b0;
      fpk_pkg::RM_UP:      to_inf = !sgn;
      fpk_pkg::RM_DOWN:    to_inf = sgn;
      default:             to_inf = 1'b1;
    endcase
    e_s = in_ctl.ebias + $signed({17'b0, r[24]});
    e_d = in_ctl.ebias + $signed({17'b0, r[53]});
    e_q = in_ctl.ebias + $signed({17'b0, r[113]});
    int_fit = (r[113:32] == '0) && (!r[31] || (sgn && (r[30:0] == '0)));
    res_next = '0;
    case (in_ctl.fmt)
      fpk_pkg::FMT_INT32: begin
        if (in_ctl.cls == fpk_pkg::CLS_ZERO) begin
          res_next.result_low = '0;
        end else if (in_ctl.int_ok && int_fit) begin
          res_next.result_low   = {32'b0, sgn ? (~r[31:0] + 32'd1) : r[31:0]};
          res_next.inexact_flag = inexact;
        end else begin
          res_next.result_low   = {32'b0, sgn ? 32'h8000_0000 : 32'h7fff_ffff};
          res_next.invalid_flag = 1'b1;
        end
      end
      fpk_pkg::FMT_SINGLE: begin
        case (in_ctl.cls)
          fpk_pkg::CLS_ZERO: res_next.result_low = {32'b0, sgn, 31'b0};
          fpk_pkg::CLS_INF:  res_next.result_low = {32'b0, sgn, 8'hff, 23'b0};
          fpk_pkg::CLS_NAN:  res_next.result_low = {32'b0, sgn, 8'hff, 1'b1, r[21:0]};
          default: begin
            res_next.inexact_flag = inexact;
            if (in_ctl.tiny) begin
              res_next.underflow_flag = 1'b1;
              res_next.result_low     = {32'b0, sgn, 7'b0, r[23:0]};
            end else if (e_s >= fpk_pkg::EmaxSingle) begin
              res_next.overflow_flag = 1'b1;
              res_next.inexact_flag  = 1'b1;
              res_next.result_low    = to_inf ? {32'b0, sgn, 8'hff, 23'b0}
                                              : {32'b0, sgn, 8'hfe, 23'h7f_ffff};
            end else begin
              res_next.result_low = {32'b0, sgn, e_s[7:0], r[22:0]};
            end
          end
        endcase
      end
      fpk_pkg::FMT_DOUBLE: begin
        case (in_ctl.cls)
          fpk_pkg::CLS_ZERO: res_next.result_low = {sgn, 63'b0};
          fpk_pkg::CLS_INF:  res_next.result_low = {sgn, 11'h7ff, 52'b0};
          fpk_pkg::CLS_NAN:  res_next.result_low = {sgn, 11'h7ff, 1'b1, r[50:0]};
          default: begin
            res_next.inexact_flag = inexact;
            if (in_ctl.tiny) begin
              res_next.underflow_flag = 1'b1;
              res_next.result_low     = {sgn, 10'b0, r[52:0]};
            end else if (e_d >= fpk_pkg::EmaxDouble) begin
              res_next.overflow_flag = 1'b1;
              res_next.inexact_flag  = 1'b1;
              res_next.result_low    = to_inf ? {sgn, 11'h7ff, 52'b0}
                                              : {sgn, 11'h7fe, {52{1'b1}}};
            end else begin
              res_next.result_low = {sgn, e_d[10:0], r[51:0]};
            end
          end
        endcase
      end
      default: begin
        case (in_ctl.cls)
          fpk_pkg::CLS_ZERO: res_next.result_high = {sgn, 63'b0};
          fpk_pkg::CLS_INF:  res_next.result_high = {sgn, 15'h7fff, 48'b0};
          fpk_pkg::CLS_NAN: begin
            res_next.result_high = {sgn, 15'h7fff, 1'b1, r[110:64]};
            res_next.result_low  = r[63:0];
          end
          default: begin
            res_next.inexact_flag = inexact;
            if (in_ctl.tiny) begin
              res_next.underflow_flag = 1'b1;
              res_next.result_high    = {sgn, 14'b0, r[112:64]};
              res_next.result_low     = r[63:0];
            end else if (e_q >= fpk_pkg::EmaxQuad) begin
              res_next.overflow_flag = 1'b1;
              res_next.inexact_flag  = 1'b1;
              res_next.result_high   = to_inf ? {sgn, 15'h7fff, 48'b0}
                                              : {sgn, 15'h7ffe, {48{1'b1}}};
              res_next.result_low    = to_inf ? 64'b0 : {64{1'b1}};
            end else begin
              res_next.result_high = {sgn, e_q[14:0], r[111:64]};
              res_next.result_low  = r[63:0];
            end
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_ctl.valid;
    end
    result <= res_next;
  end

endmodule

### hw/rtl/float_round_and_pack_unit.sv
// Float round-and-pack unit.
// Input: drive item and raise start; the item is transferred at a clock edge
// where start is high and busy is low. busy is high only during reset, so an
// item may be transferred in every cycle.
// Output: each item gives one result on result, marked by done for exactly one
// cycle. The item passes the decode, shift, round and pack registers in order;
// throughput is one item per cycle while busy is low.
// The four stages are: decode of exponent and shift count, the 113-bit
// right shift with guard/sticky, the rounding increment, and the final pack
// with flags.
// Configuration: cfg_write with cfg_data loads the rounding mode; write it
// only while no item is in flight.
// Reset clears the rounding mode to nearest-even and drops any item in flight.
// The receiver cannot stall: a result is presented once and never repeated.
module float_round_and_pack_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  fpk_pkg::item_t    item,
  output logic              done,
  output fpk_pkg::result_t  result,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_data
);

  fpk_pkg::rm_t                rounding_mode;
  logic                        accept;
  fpk_pkg::ctl_t               a_ctl;
  logic [fpk_pkg::SigW-1:0]    a_sig;
  logic                        a_g;
  logic                        a_s;
  fpk_pkg::ctl_t               r_ctl;
  logic [fpk_pkg::ExtW-1:0]    r_val;
  logic                        r_inexact;

  assign busy   = rst;
  assign accept = start && !busy;

  // Hold the rounding mode
  always_ff @(posedge clk) begin
    if (rst) begin
      rounding_mode <= fpk_pkg::RM_NEAREST;
    end else if (cfg_write) begin
      rounding_mode <= fpk_pkg::rm_t'(cfg_data);
    end
  end

  fpk_align u_align (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .mode   (rounding_mode),
    .ctl    (a_ctl),
    .sig    (a_sig),
    .g      (a_g),
    .s      (a_s)
  );

  fpk_round u_round (
    .clk     (clk),
    .rst     (rst),
    .in_ctl  (a_ctl),
    .sig     (a_sig),
    .g       (a_g),
    .s       (a_s),
    .ctl     (r_ctl),
    .rounded (r_val),
    .inexact (r_inexact)
  );

  fpk_pack u_pack (
    .clk     (clk),
    .rst     (rst),
    .in_ctl  (r_ctl),
    .r       (r_val),
    .inexact (r_inexact),
    .done    (done),
    .result  (result)
  );

  // Every transfer gives exactly one result
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done == $past(accept, 4))
    else $error("done does not follow a transfer by four cycles");

  a_ovf_inexact: assert property (@(posedge clk) disable iff (rst)
    (done && result.overflow_flag) |-> result.inexact_flag)
    else $error("overflow without inexact");

  a_invalid_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.invalid_flag && (result.inexact_flag || result.overflow_flag ||
                                       result.underflow_flag)))
    else $error("invalid raised with another flag");

  a_high_quad: assert property (@(posedge clk) disable iff (rst)
    (done && (result.result_high != '0)) |->
      ($past(item.target_format, 4) == fpk_pkg::FMT_QUAD))
    else $error("upper result half set for a narrow format");

endmodule

### verif/pack_result_checker.sv
`timescale 1ns / 100ps

module pack_result_checker
  import fpk_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    busy,
  input  item_t   item,
  input  logic    done,
  input  result_t result,
  input  logic    cfg_write,
  input  logic [1:0] cfg_data,
  output int      mismatches,
  output int      pending
);

  // Working significand: 128 bits wide, plus guard, sticky and exponent
  typedef struct packed {
    logic [127:0] bits;
    logic         g;
    logic         st;
    int           e;
  } sig_t;

  rm_t     mode;
  result_t packed_results[$];

  // Shift right by n, folding shifted-out bits into guard and sticky
  function automatic sig_t shift_sig(sig_t x, int n);
    sig_t y;
    int k;
    logic below;
    y = x;
    if (n <= 0) return y;
    k = (n > 200) ? 200 : n;
    if (k - 1 >= 128) below = |x.bits;
    else if (k == 1) below = 1'b0;
    else below = |(x.bits & ((128'd1 << (k - 1)) - 128'd1));
    y.st = x.st | x.g | below;
    y.g = (k - 1 < 128) ? x.bits[k - 1] : 1'b0;
    y.bits = (k >= 128) ? '0 : (x.bits >> k);
    return y;
  endfunction

  // Apply the rounding increment; a carry past bit 112 bumps the exponent
  function automatic sig_t round_sig(sig_t x, rm_t m, logic sn);
    sig_t y;
    logic up;
    y = x;
    case (m)
      RM_NEAREST: up = x.g;
      RM_ZERO:    up = 1'b0;
      RM_UP:      up = !sn;
      default:    up = sn;
    endcase
    if ((x.g | x.st) && up) begin
      y.bits = x.bits + 128'd1;
      if (y.bits[113]) begin
        y.e = x.e + 1;
        y.bits = 128'd1 << 112;
      end
      if (m == RM_NEAREST && !x.st) y.bits[0] = 1'b0;
    end
    return y;
  endfunction

  function automatic logic overflow_to_inf(rm_t m, logic sn);
    case (m)
      RM_NEAREST: return 1'b1;
      RM_ZERO:    return 1'b0;
      RM_UP:      return !sn;
      default:    return sn;
    endcase
  endfunction

  function automatic result_t round_and_pack(item_t it, rm_t m);
    result_t r;
    sig_t v;
    cls_t cls;
    logic sn;
    logic [63:0] top, fmask, lo;
    int fb, bias, emax;
    r = '0;
    sn = it.sign;
    cls = cls_t'(it.value_class);
    v.bits = {15'd0, it.significand_high, it.significand_low};
    v.g = it.guard_bit;
    v.st = it.sticky_bit;
    v.e = int'(it.exponent);
    case (fmt_t'(it.target_format))
      FMT_INT32: begin
        if (cls == CLS_ZERO) return r;
        if (cls == CLS_NORMAL && v.e < 32) begin
          v = shift_sig(v, 112 - v.e);
          r.inexact_flag = v.g | v.st;
          v = round_sig(v, m, sn);
          lo = v.bits[63:0];
          if (v.bits[127:64] == '0 &&
              !(lo >= 64'h80000000 && (!sn || lo > 64'h80000000))) begin
            r.result_low = sn ? ((~lo + 64'd1) & 64'hffffffff) : lo;
            return r;
          end
        end
        r.inexact_flag = 1'b0;
        r.invalid_flag = 1'b1;
        r.result_low = sn ? 64'h80000000 : 64'h7fffffff;
      end
      FMT_QUAD: begin
        top = {sn, 63'd0};
        case (cls)
          CLS_ZERO: r.result_high = top;
          CLS_INF:  r.result_high = top | (64'h7fff << 48);
          CLS_NAN: begin
            r.result_high = top | (64'h7fff << 48) | (64'd1 << 47) |
                            (v.bits[127:64] & 64'hffffffffffff);
            r.result_low = v.bits[63:0];
          end
          default: begin
            v.e = v.e + 16383;
            if (v.e <= 0) begin
              v = shift_sig(v, 1 - v.e);
              r.inexact_flag = v.g | v.st;
              v = round_sig(v, m, sn);
              r.underflow_flag = 1'b1;
              r.result_high = top | ((v.bits[127:64] >= (64'd1 << 48)) ? (64'd1 << 48) : 0) |
                              (v.bits[127:64] & 64'hffffffffffff);
              r.result_low = v.bits[63:0];
            end else begin
              r.inexact_flag = v.g | v.st;
              v = round_sig(v, m, sn);
              if (v.e >= 32'h7fff) begin
                r.overflow_flag = 1'b1;
                r.inexact_flag = 1'b1;
                if (overflow_to_inf(m, sn)) begin
                  r.result_high = top | (64'h7fff << 48);
                end else begin
                  r.result_high = top | (64'h7ffe << 48) | 64'hffffffffffff;
                  r.result_low = '1;
                end
              end else begin
                r.result_high = top | ((64'(v.e) & 64'h7fff) << 48) |
                                (v.bits[127:64] & 64'hffffffffffff);
                r.result_low = v.bits[63:0];
              end
            end
          end
        endcase
      end
      default: begin
        // Single and double share one packing path
        if (fmt_t'(it.target_format) == FMT_SINGLE) begin
          fb = 23; bias = 127; emax = 255; top = 64'(sn) << 31;
        end else begin
          fb = 52; bias = 1023; emax = 2047; top = 64'(sn) << 63;
        end
        fmask = (64'd1 << fb) - 64'd1;
        case (cls)
          CLS_ZERO: r.result_low = top;
          CLS_INF:  r.result_low = top | (64'(emax) << fb);
          default: begin
            v = shift_sig(v, 112 - fb);
            if (cls == CLS_NAN) begin
              r.result_low = top | (64'(emax) << fb) | (64'd1 << (fb - 1)) |
                             (v.bits[63:0] & (fmask >> 1));
            end else begin
              v.e = v.e + bias;
              if (v.e <= 0) begin
                v = shift_sig(v, 1 - v.e);
                r.inexact_flag = v.g | v.st;
                v = round_sig(v, m, sn);
                r.underflow_flag = 1'b1;
                if (v.bits[63:0] == (64'd1 << fb)) r.result_low = top | (64'd1 << fb);
                else r.result_low = top | (v.bits[63:0] & fmask);
              end else begin
                r.inexact_flag = v.g | v.st;
                v = round_sig(v, m, sn);
                if (v.bits[63:0] == (64'd2 << fb)) begin
                  v.bits = 128'd1 << fb;
                  v.e = v.e + 1;
                end
                if (v.e >= emax) begin
                  r.overflow_flag = 1'b1;
                  r.inexact_flag = 1'b1;
                  if (overflow_to_inf(m, sn)) r.result_low = top | (64'(emax) << fb);
                  else r.result_low = top | (64'(emax - 1) << fb) | fmask;
                end else begin
                  r.result_low = top | (64'(v.e) << fb) | (v.bits[63:0] & fmask);
                end
              end
            end
          end
        endcase
      end
    endcase
    return r;
  endfunction

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    $display("%0t: mismatch on %s: got %h, want %h", $realtime, field, got, want);
    mismatches++;
  endtask

  initial begin
    mismatches = 0;
    pending = 0;
    mode = RM_NEAREST;
  end

  // Predict on each input transfer, compare on each result transfer
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      mode = RM_NEAREST;
      packed_results.delete();
    end else begin
      if (done) begin
        if (packed_results.size() == 0) begin
          report("done", 64'd1, 64'd0);
        end else begin
          want = packed_results.pop_front();
          if (result.result_high != want.result_high)
            report("result_high", result.result_high, want.result_high);
          if (result.result_low != want.result_low)
            report("result_low", result.result_low, want.result_low);
          if (result.inexact_flag != want.inexact_flag)
            report("inexact_flag", result.inexact_flag, want.inexact_flag);
          if (result.underflow_flag != want.underflow_flag)
            report("underflow_flag", result.underflow_flag, want.underflow_flag);
          if (result.overflow_flag != want.overflow_flag)
            report("overflow_flag", result.overflow_flag, want.overflow_flag);
          if (result.invalid_flag != want.invalid_flag)
            report("invalid_flag", result.invalid_flag, want.invalid_flag);
        end
      end
      if (start && !busy) packed_results.push_back(round_and_pack(item, mode));
      if (cfg_write) mode = rm_t'(cfg_data);
    end
    pending = packed_results.size();
  end

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import fpk_pkg::*;

  localparam int PhaseItems = 257;
  localparam int IdleLimit  = 5000;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  item_t      item;
  logic       done;
  result_t    result;
  logic       cfg_write;
  logic [1:0] cfg_data;
  int         mismatches;
  int         pending;
  int         idle_cycles;

  float_round_and_pack_unit uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .cfg_write(cfg_write), .cfg_data(cfg_data)
  );

  pack_result_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic item_t mk(fmt_t f, cls_t c, logic sn, int e,
                               logic [112:0] sg, logic g, logic st);
    item_t x;
    x.target_format = f;
    x.value_class = c;
    x.sign = sn;
    x.exponent = 16'(e);
    x.significand_high = sg[112:64];
    x.significand_low = sg[63:0];
    x.guard_bit = g;
    x.sticky_bit = st;
    return x;
  endfunction

  // Mostly well-formed normals near each format's exponent range
  function automatic item_t random_operand();
    fmt_t f;
    cls_t c;
    logic [112:0] sg;
    int e, pick, k;
    f = fmt_t'($urandom_range(3));
    pick = $urandom_range(9);
    c = (pick < 7) ? CLS_NORMAL : cls_t'($urandom_range(3));
    sg = 113'({$urandom, $urandom, $urandom, $urandom});
    if ($urandom_range(9) != 0) sg[112] = 1'b1;
    if ($urandom_range(2) == 0) begin
      k = $urandom_range(112);
      sg = sg & ~((113'd1 << k) - 113'd1);
    end
    if ($urandom_range(6) == 0) e = $signed(16'($urandom));
    else begin
      case (f)
        FMT_INT32:  e = int'($urandom_range(40)) - 4;
        FMT_SINGLE: e = int'($urandom_range(300)) - 170;
        FMT_DOUBLE: e = int'($urandom_range(2150)) - 1100;
        default:    e = int'($urandom_range(32800)) - 16420;
      endcase
    end
    return mk(f, c, 1'($urandom), e, sg, 1'($urandom), 1'($urandom));
  endfunction

  // Hold the item until start meets a low busy
  task automatic transfer(item_t x);
    start <= 1'b1;
    item <= x;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_mode(rm_t m);
    drain();
    cfg_write <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic random_bursts(int n);
    int sent, burst;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(24, 1);
      for (int i = 0; i < burst && sent < n; i++) begin
        transfer(random_operand());
        sent++;
      end
      if ($urandom_range(3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(6, 1)) @(posedge clk);
      end
    end
  endtask

  // Count cycles with no transfer in either direction
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else if (idle_cycles >= IdleLimit) begin
      $display("testbench: FAIL");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    item_t directed[$];
    rm_t phases[4];
    logic [112:0] ones;
    ones = '1;
    phases = '{RM_ZERO, RM_UP, RM_DOWN, RM_NEAREST};
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_write = 1'b0;
    cfg_data = '0;
    idle_cycles = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Signed zeros, infinities and NaNs
    directed.push_back(mk(FMT_INT32, CLS_ZERO, 1, 0, '0, 0, 0));
    directed.push_back(mk(FMT_SINGLE, CLS_ZERO, 1, 0, '0, 0, 0));
    directed.push_back(mk(FMT_DOUBLE, CLS_ZERO, 0, 0, ones, 1, 1));
    directed.push_back(mk(FMT_QUAD, CLS_ZERO, 1, -32768, '0, 0, 0));
    directed.push_back(mk(FMT_INT32, CLS_INF, 1, 0, '0, 0, 0));
    directed.push_back(mk(FMT_SINGLE, CLS_INF, 0, 0, '0, 0, 0));
    directed.push_back(mk(FMT_INT32, CLS_NAN, 0, 0, ones, 0, 0));
    directed.push_back(mk(FMT_DOUBLE, CLS_NAN, 1, 0, ones >> 3, 0, 0));
    directed.push_back(mk(FMT_QUAD, CLS_NAN, 0, 0, (113'd1 << 112) | 113'd5, 0, 0));
    // Int32 edges: -2^31 fits, +2^31 does not, huge exponent, ties
    directed.push_back(mk(FMT_INT32, CLS_NORMAL, 1, 31, 113'd1 << 112, 0, 0));
    directed.push_back(mk(FMT_INT32, CLS_NORMAL, 0, 31, 113'd1 << 112, 0, 0));
    directed.push_back(mk(FMT_INT32, CLS_NORMAL, 0, 32767, ones, 0, 0));
    directed.push_back(mk(FMT_INT32, CLS_NORMAL, 0, -1, 113'd1 << 112, 0, 0));
    directed.push_back(mk(FMT_INT32, CLS_NORMAL, 1, 1, 113'd5 << 110, 0, 0));
    directed.push_back(mk(FMT_INT32, CLS_NORMAL, 0, 30, ones, 1, 1));
    // Overflow after rounding, subnormals and carry into the smallest normal
    directed.push_back(mk(FMT_SINGLE, CLS_NORMAL, 0, 127, ones, 1, 1));
    directed.push_back(mk(FMT_SINGLE, CLS_NORMAL, 1, 128, 113'd1 << 112, 0, 0));
    directed.push_back(mk(FMT_SINGLE, CLS_NORMAL, 0, -149, 113'd1 << 112, 0, 0));
    directed.push_back(mk(FMT_SINGLE, CLS_NORMAL, 0, -127, ones, 0, 0));
    directed.push_back(mk(FMT_DOUBLE, CLS_NORMAL, 1, -1100, ones, 0, 1));
    directed.push_back(mk(FMT_QUAD, CLS_NORMAL, 0, 16383, ones, 1, 1));
    directed.push_back(mk(FMT_QUAD, CLS_NORMAL, 1, 32767, ones, 0, 0));
    directed.push_back(mk(FMT_QUAD, CLS_NORMAL, 0, -16400, ones, 1, 0));
    // No leading one: processed as given
    directed.push_back(mk(FMT_SINGLE, CLS_NORMAL, 0, 0, 113'h123456789abcdef, 0, 0));
    foreach (directed[i]) transfer(directed[i]);

    // Random phases, one per rounding direction
    foreach (phases[p]) begin
      set_mode(phases[p]);
      random_bursts(PhaseItems);
    end

    drain();
    repeat (4) @(posedge clk);
    if (mismatches == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

endmodule
